/* rtl/go_back_n_sender_window_macros.svh */
// Assertion macros shared by the go-back-N sender window RTL.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gbn_pkg.sv */
// Shared constants, types and helpers for the go-back-N sender window.
// No dependencies; imported by every module of the block.
`default_nettype none

package gbn_pkg;

  localparam int SEQ_COUNT = 20;
  localparam int SEQ_W     = 5;   // sequence and wire number field width
  localparam int CNT_W     = 16;
  localparam int WIN_W     = 5;
  localparam int TO_W      = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 32;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam seq_t SEQ_LAST = seq_t'(SEQ_COUNT - 1);
  localparam seq_t WIRE_MAX = seq_t'(SEQ_COUNT);

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_ACK   = 2'd2;
  localparam logic [1:0] CMD_POLL  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam cnt_t              TOTAL_RST   = 16'd25;
  localparam logic [WIN_W-1:0]  WINDOW_RST  = 5'd10;
  localparam logic [TO_W-1:0]   TIMEOUT_RST = 8'd20;

  typedef struct packed {
    cnt_t             total;
    logic [WIN_W-1:0] window;
    logic [TO_W-1:0]  timeout;
  } cfg_t;

  // result item, send_valid in the lowest bit
  typedef struct packed {
    logic done_res;
    seq_t window_base;
    logic timeout_fired;
    cnt_t packet_index;
    seq_t send_seq;
    logic send_valid;
  } res_t;

  typedef struct packed {
    logic clr;
    logic rd_en;
    seq_t rd_addr;
    logic wr_en;
    seq_t wr_addr;
    logic wr_data;
  } mem_req_t;

  function automatic seq_t seq_inc(input seq_t a);
    seq_t r;
    r = (a == SEQ_LAST) ? '0 : a + seq_t'(1);
    return r;
  endfunction

  // (a - b) mod SEQ_COUNT for a, b below SEQ_COUNT
  function automatic seq_t seq_dist(input seq_t a, input seq_t b);
    logic [SEQ_W:0] t;
    t = {1'b0, a} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, b};
    if (t >= (SEQ_W+1)'(SEQ_COUNT)) begin
      t = t - (SEQ_W+1)'(SEQ_COUNT);
    end
    return t[SEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/gbn_flag_mem.sv */
// Acknowledged-flag store: one bit per sequence number, registered read.
// Per-entry valid bits make unwritten entries read as acknowledged.
// Depends on gbn_pkg.
`default_nettype none

module gbn_flag_mem
  import gbn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output logic          rd_flag
);

  logic                 mem_r [SEQ_COUNT];
  logic [SEQ_COUNT-1:0] vld_r;
  logic                 rd_flag_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_flag_r <= vld_r[req.rd_addr] ? mem_r[req.rd_addr] : 1'b1;
    end
  end

  assign rd_flag = rd_flag_r;

endmodule

`default_nettype wire

/* rtl/gbn_engine.sv */
// Sender window sequencer: decodes a command, walks the flag store one
// entry a cycle and keeps base, next, counts and the finished flag.
// Depends on gbn_pkg and the shared assertion macros.
`default_nettype none
`include "go_back_n_sender_window_macros.svh"

module gbn_engine
  import gbn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire seq_t       in_ackn,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res,
  output mem_req_t        mem_req,
  input  wire logic       rd_flag
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEND = 3'd1;
  localparam logic [2:0] ST_ACK  = 3'd2;
  localparam logic [2:0] ST_TOUT = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  seq_t            base_r, base_nxt;
  seq_t            next_r, next_nxt;
  cnt_t            sent_r, sent_nxt;
  cnt_t            acked_r, acked_nxt;
  logic [TO_W-1:0] epc_r, epc_nxt;
  logic            fin_r, fin_nxt;
  seq_t            ptr_r, ptr_nxt;
  seq_t            left_r, left_nxt;
  logic            pend_r, pend_nxt;
  seq_t            pend_addr_r, pend_addr_nxt;
  seq_t            rescnt_r, rescnt_nxt;
  logic            upd_r, upd_nxt;
  logic            sv_r, sv_nxt;
  seq_t            sseq_r, sseq_nxt;
  cnt_t            pidx_r, pidx_nxt;
  logic            fired_r, fired_nxt;

  seq_t            eff_win;
  seq_t            outst;
  seq_t            ack_idx;
  seq_t            ack_dist;
  logic [TO_W:0]   poll_cnt;
  logic            done_now;
  seq_t            miss_total;

  always_comb begin
    eff_win    = (cfg.window > WIN_W'(SEQ_COUNT - 1)) ? SEQ_LAST : seq_t'(cfg.window);
    outst      = seq_dist(next_r, base_r);
    ack_idx    = in_ackn - seq_t'(1);
    ack_dist   = seq_dist(ack_idx, base_r);
    poll_cnt   = {1'b0, epc_r} + (TO_W+1)'(1);
    done_now   = fin_r | (upd_r & (acked_r >= cfg.total));
    miss_total = rescnt_r + seq_t'(!rd_flag);
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    sent_nxt      = sent_r;
    acked_nxt     = acked_r;
    epc_nxt       = epc_r;
    fin_nxt       = fin_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    rescnt_nxt    = rescnt_r;
    upd_nxt       = upd_r;
    sv_nxt        = sv_r;
    sseq_nxt      = sseq_r;
    pidx_nxt      = pidx_r;
    fired_nxt     = fired_r;
    mem_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sv_nxt    = 1'b0;
          sseq_nxt  = '0;
          pidx_nxt  = '0;
          fired_nxt = 1'b0;
          upd_nxt   = 1'b1;
          state_nxt = ST_RES;
          if (in_cmd == CMD_START) begin
            mem_req.clr = 1'b1;
            base_nxt    = '0;
            next_nxt    = '0;
            sent_nxt    = '0;
            acked_nxt   = '0;
            epc_nxt     = '0;
            fin_nxt     = 1'b0;
            upd_nxt     = 1'b0;
          end else if (fin_r) begin
            upd_nxt = 1'b0;
          end else begin
            unique case (in_cmd)
              CMD_SEND: begin
                if (outst < eff_win && sent_r < cfg.total) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = next_r;
                  state_nxt       = ST_SEND;
                end
              end
              CMD_ACK: begin
                epc_nxt = '0;
                if (in_ackn != '0 && in_ackn <= WIRE_MAX && ack_dist < outst) begin
                  ptr_nxt   = base_r;
                  left_nxt  = ack_dist;
                  acked_nxt = acked_r + CNT_W'(ack_dist) + cnt_t'(1);
                  base_nxt  = seq_inc(ack_idx);
                  state_nxt = ST_ACK;
                end
              end
              CMD_POLL: begin
                if (poll_cnt > {1'b0, cfg.timeout}) begin
                  epc_nxt   = '0;
                  fired_nxt = 1'b1;
                  next_nxt  = base_r;
                  if (eff_win != '0) begin
                    ptr_nxt    = base_r;
                    left_nxt   = eff_win;
                    pend_nxt   = 1'b0;
                    rescnt_nxt = '0;
                    state_nxt  = ST_TOUT;
                  end
                end else begin
                  epc_nxt = poll_cnt[TO_W-1:0];
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_SEND: begin
        if (rd_flag) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = next_r;
          mem_req.wr_data = 1'b0;
          sv_nxt          = 1'b1;
          sseq_nxt        = next_r + seq_t'(1);
          pidx_nxt        = sent_r;
          next_nxt        = seq_inc(next_r);
          sent_nxt        = sent_r + cnt_t'(1);
        end
        state_nxt = ST_RES;
      end
      ST_ACK: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ptr_r;
        mem_req.wr_data = 1'b1;
        if (left_r == '0) begin
          state_nxt = ST_RES;
        end else begin
          ptr_nxt  = seq_inc(ptr_r);
          left_nxt = left_r - seq_t'(1);
        end
      end
      ST_TOUT: begin
        // retire the entry read last cycle, issue the next read
        if (pend_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pend_addr_r;
          mem_req.wr_data = 1'b1;
          rescnt_nxt      = miss_total;
        end
        if (left_r != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_r;
          pend_nxt        = 1'b1;
          pend_addr_nxt   = ptr_r;
          ptr_nxt         = seq_inc(ptr_r);
          left_nxt        = left_r - seq_t'(1);
        end else begin
          pend_nxt  = 1'b0;
          sent_nxt  = sent_r - CNT_W'(miss_total);
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (res_ready) begin
          fin_nxt   = done_now;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      base_r  <= '0;
      next_r  <= '0;
      sent_r  <= '0;
      acked_r <= '0;
      epc_r   <= '0;
      fin_r   <= 1'b0;
      pend_r  <= 1'b0;
      upd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      sent_r  <= sent_nxt;
      acked_r <= acked_nxt;
      epc_r   <= epc_nxt;
      fin_r   <= fin_nxt;
      pend_r  <= pend_nxt;
      upd_r   <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    left_r      <= left_nxt;
    pend_addr_r <= pend_addr_nxt;
    rescnt_r    <= rescnt_nxt;
    sv_r        <= sv_nxt;
    sseq_r      <= sseq_nxt;
    pidx_r      <= pidx_nxt;
    fired_r     <= fired_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RES);

  always_comb begin
    res.send_valid    = sv_r;
    res.send_seq      = sseq_r;
    res.packet_index  = pidx_r;
    res.timeout_fired = fired_r;
    res.window_base   = base_r;
    res.done_res      = done_now;
  end

  `GBN_ASSERT_IMP(a_ptr_range, 1'b1, base_r < WIRE_MAX && next_r < WIRE_MAX, "base or next out of range")
  `GBN_ASSERT_IMP(a_rw_apart, mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr, "flag read and write collide")
  `GBN_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state_r != ST_IDLE, "accepted item left engine idle")
  `GBN_ASSERT_NXT(a_res_handoff, res_valid && res_ready, state_r == ST_IDLE, "result handoff did not free engine")

endmodule

`default_nettype wire

/* rtl/go_back_n_sender_window.sv */
// Go-back-N sender window: one result item per input item.
// Ack items walk the acked entries of the flag store; a timeout rewind walks the
// effective window, and with a zero window it does not walk the store.
// The engine takes one item at a time; a waiting result sits in the output
// register while the next item is taken.
// Synchronous active-low reset: config to 25/10/20, flags acknowledged, counts zero.
`default_nettype none

module go_back_n_sender_window
  import gbn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,   // ack_number[4:0], zero fill
  input  wire logic [1:0]           in_tuser,   // cmd[1:0]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // send_valid[0], send_seq[5:1], packet_index[21:6], timeout_fired[22],
  // window_base[27:23], done_res[28], zero fill
  output logic [OUT_W-1:0]          out_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  mem_req_t mem_req;
  logic     rd_flag;
  logic     out_valid_r;
  res_t     out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total   <= TOTAL_RST;
      cfg_r.window  <= WINDOW_RST;
      cfg_r.timeout <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOTAL:   cfg_r.total   <= cfg_data;
        REG_WINDOW:  cfg_r.window  <= cfg_data[WIN_W-1:0];
        REG_TIMEOUT: cfg_r.timeout <= cfg_data[TO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gbn_flag_mem u_flag_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_flag (rd_flag)
  );

  gbn_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_ackn   (in_tdata[SEQ_W-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_flag   (rd_flag)
  );

  // hold the result until the sink takes it
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - $bits(res_t))'(0), out_res_r};

endmodule

`default_nettype wire
